>>> src/polyline_stroke_expander_unit_macros.svh
// assertion macros for the polyline stroke expander
`ifndef POLYLINE_STROKE_EXPANDER_UNIT_MACROS_SVH
`define POLYLINE_STROKE_EXPANDER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pse_pkg.sv
// shared types and constants for the polyline stroke expander
package pse_pkg;

  localparam int CoordW   = 24;
  localparam int OffW     = 18;
  localparam int HwW      = 16;
  localparam int CntW     = 5;
  localparam int SqrtIter = 32;
  localparam int DivIter  = 18;
  localparam logic [HwW-1:0] HwReset = 16'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQL,
    ST_SQRT,
    ST_DIVXL,
    ST_DIVX,
    ST_DIVYL,
    ST_DIVY,
    ST_EMIT1,
    ST_EMIT2,
    ST_EMITZ,
    ST_EMITO
  } pse_state_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_FIRST,
    ACC_SEG
  } pse_acc_e;

  typedef enum logic [1:0] {
    EM_STEP,
    EM_ZERO_END,
    EM_OFF_END
  } pse_emit_e;

  typedef struct packed {
    pse_acc_e  acc;
    logic      sq_go;
    logic      sqrt_load;
    logic      sqrt_step;
    logic      div_load;
    logic      div_step;
    logic      div_last;
    logic      div_sel_y;
    logic      emit;
    pse_emit_e emit_mode;
  } pse_cmd_t;

  typedef struct packed {
    logic ps_zero;
    logic ps_one;
    logic same_point;
    logic out_free;
  } pse_sts_t;

endpackage

>>> src/polyline_stroke_expander_unit.sv
// top level of the polyline stroke expander
//
// Turns a stream of polyline points into a quad strip: one left/right vertex
// pair per point, offset perpendicular to the line by half_width (Q12.4).
// A point that opens a line, repeats the held point, or closes a line on a
// repeat is accepted in the idle state with no arithmetic. A point that forms
// a new segment holds off the next point while it runs these steps: the
// squares and the root setup, the bit-pair square root of the squared length,
// and two passes of the shared restoring divider for the x and y offsets,
// then each pair into the output register. The pair of a middle
// point appears only once the following point is known; the final point
// flushes both pairs. half_width may be written only while the block is idle.
module polyline_stroke_expander_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // half_width
  // point stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // point_x [23:0], point_y [47:24]
  input  logic        s_axis_tlast_i,  // final_point
  // vertex pair stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // left_x, left_y, right_x, right_y
  output logic        m_axis_tlast_o   // end_of_strip
);

  pse_pkg::pse_cmd_t cmd;
  pse_pkg::pse_sts_t sts;

  // sequencer only sees classification of the point, not its coordinates
  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_x_i      (s_axis_tdata_i[23:0]),
    .in_y_i      (s_axis_tdata_i[47:24]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

>>> src/pse_ctrl.sv
// sequencer for the stroke expander: point classification and unit steps
`include "polyline_stroke_expander_unit_macros.svh"

module pse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  pse_pkg::pse_sts_t sts_i,
  output pse_pkg::pse_cmd_t cmd_o
);

  pse_pkg::pse_state_e state_q, state_d;
  logic [pse_pkg::CntW-1:0] cnt_q, cnt_d;
  logic fin_q, fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::ST_IDLE;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    case (state_q)
      pse_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.ps_zero) begin
            if (in_last_i) state_d = pse_pkg::ST_EMITZ;
          end else if (sts_i.same_point) begin
            if (in_last_i) begin
              state_d = sts_i.ps_one ? pse_pkg::ST_EMITZ : pse_pkg::ST_EMITO;
            end
          end else begin
            state_d = pse_pkg::ST_SQ;
            fin_d   = in_last_i;
          end
        end
      end
      pse_pkg::ST_SQ: state_d = pse_pkg::ST_SQL;
      pse_pkg::ST_SQL: begin
        state_d = pse_pkg::ST_SQRT;
        cnt_d   = pse_pkg::CntW'(pse_pkg::SqrtIter - 1);
      end
      pse_pkg::ST_SQRT: begin
        if (cnt_q == '0) state_d = pse_pkg::ST_DIVXL;
        else cnt_d = cnt_q - 1'b1;
      end
      pse_pkg::ST_DIVXL: begin
        state_d = pse_pkg::ST_DIVX;
        cnt_d   = pse_pkg::CntW'(pse_pkg::DivIter - 1);
      end
      pse_pkg::ST_DIVX: begin
        if (cnt_q == '0) state_d = pse_pkg::ST_DIVYL;
        else cnt_d = cnt_q - 1'b1;
      end
      pse_pkg::ST_DIVYL: begin
        state_d = pse_pkg::ST_DIVY;
        cnt_d   = pse_pkg::CntW'(pse_pkg::DivIter - 1);
      end
      pse_pkg::ST_DIVY: begin
        if (cnt_q == '0) state_d = pse_pkg::ST_EMIT1;
        else cnt_d = cnt_q - 1'b1;
      end
      pse_pkg::ST_EMIT1: begin
        if (sts_i.out_free) state_d = fin_q ? pse_pkg::ST_EMIT2 : pse_pkg::ST_IDLE;
      end
      pse_pkg::ST_EMIT2, pse_pkg::ST_EMITZ, pse_pkg::ST_EMITO: begin
        if (sts_i.out_free) state_d = pse_pkg::ST_IDLE;
      end
      default: state_d = pse_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.acc       = pse_pkg::ACC_NONE;
    cmd_o.emit_mode = pse_pkg::EM_STEP;
    in_ready_o      = 1'b0;
    case (state_q)
      pse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.ps_zero) cmd_o.acc = pse_pkg::ACC_FIRST;
          else if (!sts_i.same_point) cmd_o.acc = pse_pkg::ACC_SEG;
        end
      end
      pse_pkg::ST_SQ:   cmd_o.sq_go = 1'b1;
      pse_pkg::ST_SQL:  cmd_o.sqrt_load = 1'b1;
      pse_pkg::ST_SQRT: cmd_o.sqrt_step = 1'b1;
      pse_pkg::ST_DIVXL: cmd_o.div_load = 1'b1;
      pse_pkg::ST_DIVX: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = (cnt_q == '0);
      end
      pse_pkg::ST_DIVYL: begin
        cmd_o.div_load  = 1'b1;
        cmd_o.div_sel_y = 1'b1;
      end
      pse_pkg::ST_DIVY: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_last  = (cnt_q == '0);
        cmd_o.div_sel_y = 1'b1;
      end
      pse_pkg::ST_EMIT1: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_mode = pse_pkg::EM_STEP;
      end
      pse_pkg::ST_EMIT2, pse_pkg::ST_EMITO: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_mode = pse_pkg::EM_OFF_END;
      end
      pse_pkg::ST_EMITZ: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_mode = pse_pkg::EM_ZERO_END;
      end
      default: ;
    endcase
  end

  `PSE_ASSERT_IMP(a_emit_slot_free, cmd_o.emit, sts_i.out_free, "emit into a full output register")
  `PSE_ASSERT_NXT(a_seg_starts, (state_q == pse_pkg::ST_IDLE) && in_valid_i && !sts_i.ps_zero && !sts_i.same_point, state_q == pse_pkg::ST_SQ, "new segment did not start the square step")
  `PSE_ASSERT_NXT(a_sqrt_to_div, (state_q == pse_pkg::ST_SQRT) && (cnt_q == '0), state_q == pse_pkg::ST_DIVXL, "square root did not hand over to the divider")

endmodule

>>> src/pse_dp.sv
// datapath: held point, squares, square root, divider, output register
module pse_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pse_pkg::HwW-1:0]         cfg_wdata_i,
  input  logic signed [pse_pkg::CoordW-1:0] in_x_i,
  input  logic signed [pse_pkg::CoordW-1:0] in_y_i,
  input  pse_pkg::pse_cmd_t               cmd_i,
  output pse_pkg::pse_sts_t               sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [4*pse_pkg::CoordW-1:0]    out_data_o,
  output logic                            out_last_o
);

  localparam int CW = pse_pkg::CoordW;
  localparam int OW = pse_pkg::OffW;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW:0] v);
    logic signed [CW:0] hi;
    logic signed [CW:0] lo;
    hi = (CW+1)'((1 << (CW-1)) - 1);
    lo = -hi - 1'b1;
    if (v > hi) return hi[CW-1:0];
    else if (v < lo) return lo[CW-1:0];
    else return v[CW-1:0];
  endfunction

  logic [pse_pkg::HwW-1:0] hw_q;
  logic signed [CW-1:0] hx_q, hy_q, nx_q, ny_q;
  logic signed [OW-1:0] hox_q, hoy_q, ox_q, oy_q;
  logic [1:0] ps_q;
  logic signed [CW:0] dx_q, dy_q;
  logic [49:0] sx_q, sy_q;
  logic [63:0] sqn_q, sqres_q, sqbit_q;
  logic [49:0] rem_q, dsh_q;
  logic [OW-1:0] quo_q;
  logic ov_q;
  logic [4*CW-1:0] od_q;
  logic ol_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hw_q <= pse_pkg::HwReset;
    else if (cfg_we_i) hw_q <= cfg_wdata_i;
  end

  assign sts_o.ps_zero    = (ps_q == 2'd0);
  assign sts_o.ps_one     = (ps_q == 2'd1);
  assign sts_o.same_point = (in_x_i == hx_q) && (in_y_i == hy_q);
  assign sts_o.out_free   = !ov_q || out_ready_i;

  // square root step
  logic [63:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = sqres_q + sqbit_q;
  assign sq_ge  = (sqn_q >= sq_sum);

  // divider
  logic signed [CW:0] dsel;
  logic [CW:0]        dmag;
  logic [40:0]        prod;
  logic [31:0]        root;
  logic               dv_ge;
  logic [OW-1:0]      qfin;
  logic               qneg;
  logic signed [OW-1:0] qsig;
  assign dsel  = cmd_i.div_sel_y ? dx_q : dy_q;
  assign dmag  = dsel[CW] ? (CW+1)'(-dsel) : dsel;
  assign prod  = 41'(dmag) * 41'(hw_q);
  assign root  = sqres_q[31:0];
  assign dv_ge = (rem_q >= dsh_q);
  assign qfin  = {quo_q[OW-2:0], dv_ge};
  assign qneg  = cmd_i.div_sel_y ? dx_q[CW] : (!dy_q[CW] && (dy_q != '0));
  assign qsig  = qneg ? -$signed(qfin) : $signed(qfin);

  // emission
  logic signed [OW-1:0] mx, my, eox, eoy;
  logic signed [OW:0]   sumx, sumy;
  logic signed [CW:0]   lx, ly, rx, ry;
  assign sumx = (OW+1)'(hox_q) + (OW+1)'(ox_q) + 1'b1;
  assign sumy = (OW+1)'(hoy_q) + (OW+1)'(oy_q) + 1'b1;
  assign mx   = sumx[OW:1];
  assign my   = sumy[OW:1];

  always_comb begin
    case (cmd_i.emit_mode)
      pse_pkg::EM_STEP: begin
        eox = (ps_q == 2'd1) ? ox_q : mx;
        eoy = (ps_q == 2'd1) ? oy_q : my;
      end
      pse_pkg::EM_OFF_END: begin
        eox = hox_q;
        eoy = hoy_q;
      end
      default: begin
        eox = '0;
        eoy = '0;
      end
    endcase
  end

  assign lx = (CW+1)'(hx_q) + (CW+1)'(eox);
  assign ly = (CW+1)'(hy_q) + (CW+1)'(eoy);
  assign rx = (CW+1)'(hx_q) - (CW+1)'(eox);
  assign ry = (CW+1)'(hy_q) - (CW+1)'(eoy);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q  <= 2'd0;
      ov_q  <= 1'b0;
      hx_q  <= '0;
      hy_q  <= '0;
      hox_q <= '0;
      hoy_q <= '0;
    end else begin
      if (cmd_i.acc == pse_pkg::ACC_FIRST) begin
        hx_q <= in_x_i;
        hy_q <= in_y_i;
        ps_q <= 2'd1;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
        if (cmd_i.emit_mode == pse_pkg::EM_STEP) begin
          hx_q  <= nx_q;
          hy_q  <= ny_q;
          hox_q <= ox_q;
          hoy_q <= oy_q;
          ps_q  <= 2'd2;
        end else begin
          ps_q <= 2'd0;
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc == pse_pkg::ACC_SEG) begin
      nx_q <= in_x_i;
      ny_q <= in_y_i;
      dx_q <= (CW+1)'(in_x_i) - (CW+1)'(hx_q);
      dy_q <= (CW+1)'(in_y_i) - (CW+1)'(hy_q);
    end
    if (cmd_i.sq_go) begin
      sx_q <= 50'(dx_q * dx_q);
      sy_q <= 50'(dy_q * dy_q);
    end
    if (cmd_i.sqrt_load) begin
      sqn_q   <= {sx_q + sy_q, 14'b0};
      sqres_q <= '0;
      sqbit_q <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        sqn_q   <= sqn_q - sq_sum;
        sqres_q <= (sqres_q >> 1) + sqbit_q;
      end else begin
        sqres_q <= sqres_q >> 1;
      end
      sqbit_q <= sqbit_q >> 2;
    end
    if (cmd_i.div_load) begin
      rem_q <= {1'b0, prod, 8'b0} + 50'(root);
      dsh_q <= {root, 18'b0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dv_ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= qfin;
      if (cmd_i.div_last) begin
        if (cmd_i.div_sel_y) oy_q <= qsig;
        else ox_q <= qsig;
      end
    end
    if (cmd_i.emit) begin
      od_q <= {sat(ry), sat(rx), sat(ly), sat(lx)};
      ol_q <= (cmd_i.emit_mode != pse_pkg::EM_STEP);
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

endmodule
